// ===== sv/ogr_pkg.sv =====
// Package for the OLED text glyph renderer: font table, job struct, constants.
// No dependencies; used by the top level, ogr_cursor and ogr_emitter.
`timescale 1ns / 1ps
`default_nettype none
package ogr_pkg;

	localparam int GlyphWidth = 6;
	localparam int GlyphCount = 37;
	localparam int RomRows    = 37;
	localparam int ColW       = 8;
	localparam int PageW      = 8;
	localparam int CursorW    = ColW + PageW;
	localparam int CursorDepth = 2;   // entry 0 holds the cursor, entry 1 is spare
	localparam int SeqLast    = 8;    // three commands then six data bytes

	localparam logic [7:0] WrapLimit   = 8'd126;
	localparam logic [7:0] CmdPageBase = 8'hB0;
	localparam logic [7:0] CmdColHigh  = 8'h10;
	localparam logic [7:0] ColLowForce = 8'h01;
	localparam logic [7:0] DigitBase   = 8'd48;
	localparam logic [7:0] AlphaBase   = 8'd54;
	localparam logic [7:0] AlphaStart  = 8'd65;

	typedef enum logic [3:0] {
		SEQ_PAGE  = 4'd0,
		SEQ_COLHI = 4'd1,
		SEQ_COLLO = 4'd2
	} seq_cmd_t;

	typedef struct packed {
		logic [PageW-1:0] page;
		logic [ColW-1:0]  col;
		logic [7:0]       idx;
	} job_t;

	// Rows packed column 0 in the top byte.
	localparam logic [47:0] FONT [RomRows] = '{
		48'h003E5149453E, 48'h0000427F4000, 48'h004261514946, 48'h002141454B31,
		48'h001814127F10, 48'h002745454539, 48'h003C4A494930, 48'h000171090503,
		48'h003649494936, 48'h00064949291E, 48'h000036360000, 48'h007C1211127C,
		48'h007F49494936, 48'h003E41414122, 48'h007F4141221C, 48'h007F49494941,
		48'h007F09090901, 48'h003E4149497A, 48'h007F0808087F, 48'h0000417F4100,
		48'h002040413F01, 48'h007F08142241, 48'h007F40404040, 48'h007F020C027F,
		48'h007F0408107F, 48'h003E4141413E, 48'h007F09090906, 48'h003E4151215E,
		48'h007F09192946, 48'h004649494931, 48'h0001017F0101, 48'h003F4040403F,
		48'h001F2040201F, 48'h003F4038403F, 48'h006314081463, 48'h000708700807,
		48'h006151494543
	};

	function automatic logic [7:0] glyph_byte(input logic [7:0] idx, input logic [2:0] col);
		logic [47:0] row;
		logic [7:0]  b;
		row = 48'h0;
		if ((idx < 8'(GlyphCount)) && (idx < 8'(RomRows))) begin
			row = FONT[idx[5:0]];
		end
		case (col)
			3'd0: b = row[47:40];
			3'd1: b = row[39:32];
			3'd2: b = row[31:24];
			3'd3: b = row[23:16];
			3'd4: b = row[15:8];
			3'd5: b = row[7:0];
			default: b = 8'h00;
		endcase
		return b;
	endfunction

endpackage
`default_nettype wire

// ===== sv/oled_text_glyph_renderer_unit.sv =====
// Top level of the OLED text glyph renderer (6x8 font, SSD1306-style commands).
// Instantiates ogr_cursor and ogr_emitter; uses ogr_pkg.
//
//   channel | signals                                      | dir
//   --------+----------------------------------------------+-----
//   in      | in_valid, in_ready, new_string, start_column, | in
//           | start_page, char_code                        |
//   out     | out_valid, out_ready, is_data, payload,       | out
//           | last_of_char                                 |
//
// Each character yields nine transactions, one per cycle when out_ready is
// held high; the single result port sets the sustained rate. A character is
// registered in the input stage and then in the emitter before its first
// result. The next character waits in the input stage, with its cursor read
// already issued, while the current one is emitted. Reset clears all control
// state; the cursor RAM is treated as zero until first written. A stall on
// out_ready holds the current transaction and backs up into in_ready.
`timescale 1ns / 1ps
`default_nettype none
module oled_text_glyph_renderer_unit #(
	parameter int CURSOR_DEPTH = ogr_pkg::CursorDepth
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire logic       new_string,
	input  wire logic [6:0] start_column,
	input  wire logic [2:0] start_page,
	input  wire logic [7:0] char_code,
	output logic            out_valid,
	input  wire logic       out_ready,
	output logic            is_data,
	output logic [7:0]      payload,
	output logic            last_of_char
);

	logic           job_valid;
	logic           job_ready;
	ogr_pkg::job_t  job;

	ogr_cursor #(
		.CURSOR_DEPTH(CURSOR_DEPTH)
	) u_cursor (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.new_string  (new_string),
		.start_column(start_column),
		.start_page  (start_page),
		.char_code   (char_code),
		.job_valid   (job_valid),
		.job_ready   (job_ready),
		.job         (job)
	);

	ogr_emitter u_emitter (
		.clk         (clk),
		.arst_n      (arst_n),
		.job_valid   (job_valid),
		.job_ready   (job_ready),
		.job         (job),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.is_data     (is_data),
		.payload     (payload),
		.last_of_char(last_of_char)
	);

endmodule
`default_nettype wire

// ===== sv/ogr_ram.sv =====
// Generic single-port synchronous RAM, registered read (read-first).
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module ogr_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 2
) (
	input  wire logic                     clk,
	input  wire logic                     rd_en,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(DEPTH)-1:0] addr,
	input  wire logic [WIDTH-1:0]         wdata,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rdata <= mem[addr];
		end
		if (wr_en) begin
			mem[addr] <= wdata;
		end
	end

endmodule
`default_nettype wire

// ===== sv/ogr_cursor.sv =====
// Input stage and cursor update: cursor kept in ogr_ram, read on accept,
// written back when the character moves on to the emitter. Uses ogr_pkg.
`timescale 1ns / 1ps
`default_nettype none
module ogr_cursor #(
	parameter int CURSOR_DEPTH = ogr_pkg::CursorDepth
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            in_valid,
	output logic                 in_ready,
	input  wire logic            new_string,
	input  wire logic [6:0]      start_column,
	input  wire logic [2:0]      start_page,
	input  wire logic [7:0]      char_code,
	output logic                 job_valid,
	input  wire logic            job_ready,
	output ogr_pkg::job_t        job
);

	logic                         valid_s1;
	logic                         new_string_s1;
	logic [6:0]                   start_column_s1;
	logic [2:0]                   start_page_s1;
	logic [7:0]                   char_code_s1;
	logic                         written_q;
	logic                         fwd_q;
	logic [ogr_pkg::CursorW-1:0]  fwd_data_q;
	logic [ogr_pkg::CursorW-1:0]  rd_data;
	logic [ogr_pkg::CursorW-1:0]  cur;
	logic [ogr_pkg::CursorW-1:0]  wr_data;
	logic [ogr_pkg::ColW-1:0]     col;
	logic [ogr_pkg::PageW-1:0]    page;
	logic [ogr_pkg::ColW-1:0]     col_next;
	logic                         accept;
	logic                         advance;

	assign advance  = valid_s1 & job_ready;
	assign in_ready = ~valid_s1 | job_ready;
	assign accept   = in_valid & in_ready;

	ogr_ram #(
		.WIDTH(ogr_pkg::CursorW),
		.DEPTH(CURSOR_DEPTH)
	) u_cursor_ram (
		.clk  (clk),
		.rd_en(accept),
		.wr_en(advance),
		.addr ('0),
		.wdata(wr_data),
		.rdata(rd_data)
	);

	// A write at the same edge as the read means the RAM returned stale data.
	always_comb begin
		if (fwd_q) begin
			cur = fwd_data_q;
		end else if (written_q) begin
			cur = rd_data;
		end else begin
			cur = '0;
		end
		if (new_string_s1) begin
			col  = {1'b0, start_column_s1};
			page = {5'b0, start_page_s1};
		end else begin
			col  = cur[ogr_pkg::ColW-1:0];
			page = cur[ogr_pkg::CursorW-1:ogr_pkg::ColW];
		end
		if (col > ogr_pkg::WrapLimit) begin
			col  = '0;
			page = page + 8'd1;
		end
		col_next = col + 8'(ogr_pkg::GlyphWidth);
		wr_data  = {page, col_next};
		job.page = page;
		job.col  = col;
		if (char_code_s1 < ogr_pkg::AlphaStart) begin
			job.idx = char_code_s1 - ogr_pkg::DigitBase;
		end else begin
			job.idx = char_code_s1 - ogr_pkg::AlphaBase;
		end
	end

	assign job_valid = valid_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1  <= 1'b0;
			written_q <= 1'b0;
			fwd_q     <= 1'b0;
		end else begin
			if (accept) begin
				valid_s1 <= 1'b1;
				fwd_q    <= advance;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (advance) begin
				written_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			new_string_s1   <= new_string;
			start_column_s1 <= start_column;
			start_page_s1   <= start_page;
			char_code_s1    <= char_code;
		end
		if (advance) begin
			fwd_data_q <= wr_data;
		end
	end

endmodule
`default_nettype wire

// ===== sv/ogr_emitter.sv =====
// Result sequencer: holds one character job and emits its nine transactions.
// Uses ogr_pkg for the job struct, command bytes and font lookup.
`timescale 1ns / 1ps
`default_nettype none
module ogr_emitter (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           job_valid,
	output logic                job_ready,
	input  wire ogr_pkg::job_t  job,
	output logic                out_valid,
	input  wire logic           out_ready,
	output logic                is_data,
	output logic [7:0]          payload,
	output logic                last_of_char
);

	logic           valid_q;
	logic [3:0]     cnt_q;
	ogr_pkg::job_t  job_q;
	logic           done;

	assign done      = out_ready & (cnt_q == 4'(ogr_pkg::SeqLast));
	assign job_ready = ~valid_q | done;
	assign out_valid = valid_q;

	always_comb begin
		is_data      = 1'b0;
		last_of_char = 1'b0;
		case (cnt_q)
			ogr_pkg::SEQ_PAGE:  payload = ogr_pkg::CmdPageBase + job_q.page;
			ogr_pkg::SEQ_COLHI: payload = ogr_pkg::CmdColHigh | {4'h0, job_q.col[7:4]};
			ogr_pkg::SEQ_COLLO: payload = {4'h0, job_q.col[3:0]} | ogr_pkg::ColLowForce;
			default: begin
				is_data      = 1'b1;
				last_of_char = (cnt_q == 4'(ogr_pkg::SeqLast));
				payload      = ogr_pkg::glyph_byte(job_q.idx, 3'(cnt_q - 4'd3));
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			cnt_q   <= '0;
		end else begin
			if (job_ready) begin
				valid_q <= job_valid;
				cnt_q   <= '0;
			end else if (out_ready) begin
				cnt_q <= cnt_q + 4'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (job_ready && job_valid) begin
			job_q <= job;
		end
	end

endmodule
`default_nettype wire

// ===== tb/sv/tb_top.sv =====
// Self-checking testbench for oled_text_glyph_renderer_unit: drives characters, predicts
// the nine display transactions per character and checks them in order.
// Depends only on the renderer RTL; no files or arguments are read.
`timescale 1ns / 1ps

typedef struct packed {
	logic       is_data;
	logic [7:0] payload;
	logic       last_of_char;
} display_txn_t;

class glyph_scoreboard;
	logic [7:0]   cursor_col;
	logic [7:0]   cursor_page;
	display_txn_t pending_txns[$];
	int           mismatches;
	int           txns_checked;

	function new();
		cursor_col   = 8'd0;
		cursor_page  = 8'd0;
		mismatches   = 0;
		txns_checked = 0;
	endfunction

	// 6x8 font, column 0 in the top byte; anything past the table is blank
	function logic [47:0] glyph_row(input logic [7:0] idx);
		case (idx)
			8'd0:  return 48'h003E5149453E;
			8'd1:  return 48'h0000427F4000;
			8'd2:  return 48'h004261514946;
			8'd3:  return 48'h002141454B31;
			8'd4:  return 48'h001814127F10;
			8'd5:  return 48'h002745454539;
			8'd6:  return 48'h003C4A494930;
			8'd7:  return 48'h000171090503;
			8'd8:  return 48'h003649494936;
			8'd9:  return 48'h00064949291E;
			8'd10: return 48'h000036360000;
			8'd11: return 48'h007C1211127C;
			8'd12: return 48'h007F49494936;
			8'd13: return 48'h003E41414122;
			8'd14: return 48'h007F4141221C;
			8'd15: return 48'h007F49494941;
			8'd16: return 48'h007F09090901;
			8'd17: return 48'h003E4149497A;
			8'd18: return 48'h007F0808087F;
			8'd19: return 48'h0000417F4100;
			8'd20: return 48'h002040413F01;
			8'd21: return 48'h007F08142241;
			8'd22: return 48'h007F40404040;
			8'd23: return 48'h007F020C027F;
			8'd24: return 48'h007F0408107F;
			8'd25: return 48'h003E4141413E;
			8'd26: return 48'h007F09090906;
			8'd27: return 48'h003E4151215E;
			8'd28: return 48'h007F09192946;
			8'd29: return 48'h004649494931;
			8'd30: return 48'h0001017F0101;
			8'd31: return 48'h003F4040403F;
			8'd32: return 48'h001F2040201F;
			8'd33: return 48'h003F4038403F;
			8'd34: return 48'h006314081463;
			8'd35: return 48'h000708700807;
			8'd36: return 48'h006151494543;
			default: return 48'h0;
		endcase
	endfunction

	function void queue_txn(input logic d, input logic [7:0] p, input logic l);
		display_txn_t t;
		t.is_data      = d;
		t.payload      = p;
		t.last_of_char = l;
		pending_txns.push_back(t);
	endfunction

	// Works out the transactions one accepted character causes
	function void render_char(input logic ns, input logic [6:0] sc, input logic [2:0] sp,
			input logic [7:0] cc);
		logic [7:0]  idx;
		logic [47:0] row;
		int          i;
		if (ns) begin
			cursor_col  = {1'b0, sc};
			cursor_page = {5'b0, sp};
		end
		idx = (cc < 8'd65) ? cc - 8'd48 : cc - 8'd54;
		if (cursor_col > 8'd126) begin
			cursor_col  = 8'd0;
			cursor_page = cursor_page + 8'd1;
		end
		queue_txn(1'b0, 8'hB0 + cursor_page, 1'b0);
		queue_txn(1'b0, 8'h10 | {4'h0, cursor_col[7:4]}, 1'b0);
		// low-nibble command always has bit 0 set
		queue_txn(1'b0, {4'h0, cursor_col[3:0]} | 8'h01, 1'b0);
		row = glyph_row(idx);
		for (i = 0; i < 6; i++)
			queue_txn(1'b1, row[47 - 8*i -: 8], i == 5);
		cursor_col = cursor_col + 8'd6;
	endfunction

	function void check_txn(input display_txn_t got);
		display_txn_t want;
		txns_checked++;
		if (pending_txns.size() == 0) begin
			mismatches++;
			if (mismatches <= 10)
				$display("%0t: unexpected transaction is_data=%0b payload=%02h last=%0b",
					$time, got.is_data, got.payload, got.last_of_char);
			return;
		end
		want = pending_txns.pop_front();
		if (got.is_data !== want.is_data || got.payload !== want.payload ||
				got.last_of_char !== want.last_of_char) begin
			mismatches++;
			if (mismatches <= 10)
				$display("%0t: mismatch expected is_data=%0b payload=%02h last=%0b, got is_data=%0b payload=%02h last=%0b",
					$time, want.is_data, want.payload, want.last_of_char,
					got.is_data, got.payload, got.last_of_char);
		end
	endfunction
endclass

module tb_top;
	localparam int NumRandomChars = 220;
	localparam int HoldOffCycles  = 300;
	localparam int TailCycles     = 20;
	localparam int TimeoutCycles  = 200000;

	logic       clk = 1'b0;
	logic       arst_n;
	logic       in_valid;
	logic       in_ready;
	logic       new_string;
	logic [6:0] start_column;
	logic [2:0] start_page;
	logic [7:0] char_code;
	logic       out_valid;
	logic       out_ready;
	logic       is_data;
	logic [7:0] payload;
	logic       last_of_char;

	glyph_scoreboard board = new();

	int idle_pct = 13;
	bit hold_request = 1'b0;
	bit hold_done = 1'b0;
	int chars_sent = 0;
	int strings_started = 0;

	oled_text_glyph_renderer_unit i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.new_string   (new_string),
		.start_column (start_column),
		.start_page   (start_page),
		.char_code    (char_code),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.is_data      (is_data),
		.payload      (payload),
		.last_of_char (last_of_char)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		if (arst_n && in_valid && in_ready)
			board.render_char(new_string, start_column, start_page, char_code);
		if (arst_n && out_valid && out_ready)
			board.check_txn({is_data, payload, last_of_char});
	end

	// Called at a falling edge; returns at the falling edge after the transaction
	task automatic send_char(input logic ns, input logic [6:0] sc, input logic [2:0] sp,
			input logic [7:0] cc);
		while ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid     <= 1'b1;
		new_string   <= ns;
		start_column <= sc;
		start_page   <= sp;
		char_code    <= cc;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		@(negedge clk);
		chars_sent++;
		if (ns)
			strings_started++;
	endtask

	// Mostly font characters, some codes that alias onto A..F, some anything at all
	function automatic logic [7:0] pick_code();
		int r;
		int g;
		r = $urandom_range(99);
		g = $urandom_range(36);
		if (r < 75)
			return (g < 11) ? 8'(48 + g) : 8'(54 + g);
		if (r < 85)
			return 8'($urandom_range(64, 59));
		return 8'($urandom_range(255));
	endfunction

	initial begin
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_request) begin
				hold_request = 1'b0;
				out_ready <= 1'b0;
				repeat (HoldOffCycles) @(negedge clk);
			end
			out_ready <= ($urandom_range(99) >= idle_pct);
		end
	end

	initial begin
		int         len;
		int         n;
		int         target;
		logic [6:0] col;
		logic [2:0] pg;
		arst_n       = 1'b0;
		in_valid     = 1'b0;
		new_string   = 1'b0;
		start_column = 7'd0;
		start_page   = 3'd0;
		char_code    = 8'd0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// cursor from reset, digit and colon edges, codes aliasing onto A..F, letters
		send_char(1'b0, 7'd0, 3'd0, 8'd48);
		send_char(1'b0, 7'd0, 3'd0, 8'd57);
		send_char(1'b0, 7'd0, 3'd0, 8'd58);
		send_char(1'b0, 7'd0, 3'd0, 8'd59);
		send_char(1'b0, 7'd0, 3'd0, 8'd64);
		send_char(1'b0, 7'd0, 3'd0, 8'd65);
		send_char(1'b0, 7'd0, 3'd0, 8'd90);
		// blank glyphs: just past the table, below '0', and the code extremes
		send_char(1'b0, 7'd0, 3'd0, 8'd91);
		send_char(1'b0, 7'd0, 3'd0, 8'd47);
		send_char(1'b0, 7'd0, 3'd0, 8'd0);
		send_char(1'b0, 7'd0, 3'd0, 8'd255);
		send_char(1'b0, 7'd0, 3'd0, 8'd128);
		// start column past the wrap limit, then wrap from the last page to page 8
		send_char(1'b1, 7'd127, 3'd0, "B");
		send_char(1'b1, 7'd126, 3'd7, "C");
		send_char(1'b0, 7'd0, 3'd0, "D");
		send_char(1'b0, 7'd0, 3'd0, "E");
		send_char(1'b1, 7'd127, 3'd7, "F");
		send_char(1'b1, 7'd85, 3'd5, "G");
		send_char(1'b1, 7'd42, 3'd2, "M");
		send_char(1'b1, 7'd120, 3'd3, "W");
		// start fields set but ignored, then a colon starting a new string
		send_char(1'b0, 7'd127, 3'd7, "X");
		send_char(1'b0, 7'd127, 3'd7, "Y");
		send_char(1'b1, 7'd0, 3'd0, ":");

		target = chars_sent + NumRandomChars;
		while (chars_sent < target) begin
			col = ($urandom_range(3) == 0) ? 7'($urandom_range(127, 110)) : 7'($urandom_range(127));
			pg  = 3'($urandom_range(7));
			len = ($urandom_range(7) == 0) ? $urandom_range(45, 20) : $urandom_range(12, 1);
			for (n = 0; n < len && chars_sent < target; n++) begin
				if (!hold_done && chars_sent >= 80) begin
					hold_request = 1'b1;
					hold_done    = 1'b1;
				end
				idle_pct = (chars_sent >= 140 && chars_sent < 190) ? 0 : 13;
				if (n == 0)
					send_char(1'b1, col, pg, pick_code());
				else
					send_char(1'b0, 7'($urandom_range(127)), 3'($urandom_range(7)), pick_code());
			end
		end
		in_valid <= 1'b0;

		while (board.pending_txns.size() != 0)
			@(posedge clk);
		repeat (TailCycles) @(posedge clk);

		$display("Rendered %0d characters in %0d strings, %0d transactions checked, %0d mismatches.",
			chars_sent, strings_started, board.txns_checked, board.mismatches);
		$display("Covered code aliasing, blank glyphs, column wrap, pages past 7 and a long output stall.");
		if (board.mismatches == 0 && board.pending_txns.size() == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

	initial begin
		#(TimeoutCycles * 10);
		$display("Some tests failed");
		$finish;
	end
endmodule

// ===== sim.f =====
sv/ogr_pkg.sv
sv/ogr_ram.sv
sv/ogr_cursor.sv
sv/ogr_emitter.sv
sv/oled_text_glyph_renderer_unit.sv
tb/sv/tb_top.sv
